FILE: hdl/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, sizes and command codes for the stage planner.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int PHASES     = 16;
    localparam int RINGS      = 4;
    localparam int MAX_STAGES = 16;

    localparam int PH_W   = $clog2(PHASES);
    localparam int RG_W   = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int ST_W   = $clog2(MAX_STAGES);
    localparam int SEQ_D  = RINGS * PHASES;
    localparam int SEQ_W  = $clog2(SEQ_D);
    localparam int ID_W   = 5;
    localparam int CNT_W  = 5;

    localparam logic [1:0] KIND_SPLIT = 2'd0;
    localparam logic [1:0] KIND_SLOT  = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;
    localparam logic [1:0] KIND_MOVE  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_STAGE = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] phase_index;
        logic [1:0] ring_index;
        logic [3:0] slot_index;
        logic [7:0] table_value;
        logic [4:0] stage_number;
        logic [7:0] cycle_time;
        logic [7:0] elapsed_time;
    } ssp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  stage_count;
        logic [4:0]  current_stage;
        logic [4:0]  next_stage;
        logic [15:0] green_phases;
    } ssp_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch the command
        logic wr_split;
        logic wr_slot;
        logic build_init;  // clear plan state
        logic walk_start;  // start ring walk: r=0, i=0, total=0
        logic walk_step;   // one slot of the walk
        logic time_next;   // end of one time pass
        logic build_fin;
        logic move_init;   // check target, set up move walk
        logic move_fin;
        logic out_load;    // copy the result into the output register
    } ssp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;   // all rings walked
        logic time_done;   // t reached cycle_time
        logic move_bad;    // target invalid
    } ssp_sts_t;

endpackage

FILE: hdl/ssp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_ctrl
// Command sequencer: handshakes and the walk of build and move commands.
// ----------------------------------------------------------------------------
module ssp_ctrl import ssp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic [1:0] s_kind,
    output logic     m_valid,
    input  logic     m_ready,
    output ssp_cmd_t cmd,
    input  ssp_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_MWALK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic [1:0] kind_reg, kind_next;

    // accept whenever idle; the output register holds the previous result
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        kind_next   = kind_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    kind_next  = s_kind;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                case (kind_reg)
                    KIND_SPLIT: begin
                        cmd.wr_split = 1'b1;
                        state_next   = S_DONE;
                    end
                    KIND_SLOT: begin
                        cmd.wr_slot = 1'b1;
                        state_next  = S_DONE;
                    end
                    KIND_BUILD: begin
                        cmd.build_init = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK;
                    end
                    default: begin
                        cmd.move_init  = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_next     = S_MWALK;
                    end
                endcase
            end
            S_WALK: begin
                if (sts.time_done) begin
                    cmd.build_fin = 1'b1;
                    state_next    = S_DONE;
                end else if (sts.walk_done) begin
                    cmd.time_next = 1'b1;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_MWALK: begin
                if (sts.move_bad) begin
                    state_next = S_DONE;
                end else if (sts.walk_done) begin
                    cmd.move_fin = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DONE: begin
                // wait here while the output register still holds a beat
                if (!mvalid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            kind_reg   <= KIND_SPLIT;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            kind_reg   <= kind_next;
        end
    end

endmodule

FILE: hdl/ssp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_dp
// Tables, ring walker, stage store and result registers.
// ----------------------------------------------------------------------------
module ssp_dp import ssp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  ssp_in_t  s_data,
    input  ssp_cmd_t cmd,
    output ssp_sts_t sts,
    output ssp_out_t m_data
);

    // tables are small; each entry has a reset
    logic [7:0]      split_reg [PHASES];
    logic [ID_W-1:0] seq_reg   [SEQ_D];
    logic [7:0]      start_reg [MAX_STAGES];

    ssp_in_t         cmd_reg;
    logic [CNT_W-1:0] total_reg, active_reg, follow_reg;
    logic [15:0]     green_reg;
    logic [1:0]      status_reg;
    ssp_out_t        out_reg;

    // walk state
    logic [RG_W-1:0] r_reg;
    logic [PH_W:0]   i_reg;
    logic            rdone_reg;   // ring ended early by a move hit
    logic            alldone_reg;
    logic [7:0]      sum_reg;
    logic [8:0]      t_reg;
    logic [7:0]      last_reg;
    logic [CNT_W-1:0] count_reg, cur_reg;
    logic            ovf_reg;
    logic [7:0]      mstart_reg;
    logic [CNT_W-1:0] target_reg;
    logic            bad_reg;
    logic [15:0]     mask_reg;
    logic [ID_W-1:0] seq_q_reg;   // registered read of the ring sequence

    logic [ID_W-1:0]  id;
    logic [7:0]       sum_new;
    logic             id_ok;
    logic             end_ring;
    logic [SEQ_W-1:0] rd_addr;
    logic [CNT_W-1:0] target_c;

    assign id       = seq_q_reg;
    assign id_ok    = (id != '0) && (id <= ID_W'(PHASES));
    assign sum_new  = sum_reg + split_reg[PH_W'(id - 1'b1)];
    assign end_ring = rdone_reg || (i_reg == (PH_W+1)'(PHASES)) || !id_ok;
    assign target_c = (cmd_reg.stage_number == '0) ? follow_reg : cmd_reg.stage_number;

    // read address runs one slot ahead, so the data lands with r_reg/i_reg
    always_comb begin
        rd_addr = {r_reg, i_reg[PH_W-1:0]};
        if (cmd.walk_start || cmd.time_next) begin
            rd_addr = '0;
        end else if (cmd.walk_step) begin
            if (!end_ring) begin
                rd_addr = {r_reg, PH_W'(i_reg + 1'b1)};
            end else if (32'(r_reg) != RINGS - 1) begin
                rd_addr = {RG_W'(r_reg + 1'b1), {PH_W{1'b0}}};
            end
        end
    end

    assign sts.walk_done = alldone_reg;
    assign sts.time_done = (t_reg >= {1'b0, cmd_reg.cycle_time});
    assign sts.move_bad  = bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PHASES; k++) split_reg[k] <= '0;
            for (int k = 0; k < SEQ_D; k++) seq_reg[k] <= '0;
            for (int k = 0; k < MAX_STAGES; k++) start_reg[k] <= '0;
            total_reg  <= '0;
            active_reg <= '0;
            follow_reg <= '0;
            green_reg  <= '0;
            status_reg <= STAT_OK;
            out_reg    <= '0;
            alldone_reg <= 1'b0;
            bad_reg    <= 1'b0;
            r_reg      <= '0;
            i_reg      <= '0;
            seq_q_reg  <= '0;
        end else begin
            seq_q_reg <= seq_reg[rd_addr];
            if (cmd.load) begin
                cmd_reg    <= s_data;
                status_reg <= STAT_OK;
            end
            if (cmd.wr_split && (32'(cmd_reg.phase_index) < PHASES)) begin
                split_reg[PH_W'(cmd_reg.phase_index)] <= cmd_reg.table_value;
            end
            if (cmd.wr_slot && (32'(cmd_reg.ring_index) < RINGS)
                    && (32'(cmd_reg.slot_index) < PHASES)) begin
                seq_reg[{RG_W'(cmd_reg.ring_index), PH_W'(cmd_reg.slot_index)}] <=
                    (cmd_reg.table_value <= 8'(PHASES)) ? ID_W'(cmd_reg.table_value) : '0;
            end
            if (cmd.build_init) begin
                for (int k = 0; k < MAX_STAGES; k++) start_reg[k] <= '0;
                t_reg     <= '0;
                last_reg  <= '0;
                count_reg <= CNT_W'(1);
                cur_reg   <= CNT_W'(1);
                ovf_reg   <= 1'b0;
            end
            if (cmd.move_init) begin
                bad_reg    <= (total_reg == '0) || (target_c == '0) || (target_c > total_reg);
                target_reg <= target_c;
                mstart_reg <= start_reg[ST_W'(target_c - 1'b1)];
                mask_reg   <= '0;
                if ((total_reg == '0) || (target_c == '0) || (target_c > total_reg))
                    status_reg <= STAT_NO_STAGE;
            end
            if (cmd.walk_start || cmd.time_next) begin
                r_reg       <= '0;
                i_reg       <= '0;
                sum_reg     <= '0;
                rdone_reg   <= 1'b0;
                alldone_reg <= 1'b0;
            end
            if (cmd.time_next) begin
                if (t_reg + 9'd1 == {1'b0, cmd_reg.elapsed_time}) cur_reg <= count_reg;
                t_reg <= t_reg + 9'd1;
            end
            if (cmd.walk_step) begin
                if (!end_ring) begin
                    sum_reg <= sum_new;
                    if (cmd_reg.kind == KIND_BUILD) begin
                        if ({1'b0, sum_new} == t_reg && sum_new > last_reg) begin
                            last_reg <= sum_new;
                            if (32'(count_reg) < MAX_STAGES) begin
                                start_reg[ST_W'(count_reg)] <= sum_new;
                                count_reg <= count_reg + 1'b1;
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                        end
                    end else if (sum_new > mstart_reg) begin
                        if (id <= ID_W'(16)) mask_reg[4'(id - 1'b1)] <= 1'b1;
                        rdone_reg <= 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end else begin
                    sum_reg   <= '0;
                    i_reg     <= '0;
                    rdone_reg <= 1'b0;
                    if (32'(r_reg) == RINGS - 1) alldone_reg <= 1'b1;
                    else r_reg <= r_reg + 1'b1;
                end
            end
            if (cmd.build_fin) begin
                total_reg  <= count_reg;
                active_reg <= cur_reg;
                follow_reg <= (cur_reg + 1'b1 > count_reg) ? CNT_W'(1) : cur_reg + 1'b1;
                green_reg  <= '0;
                status_reg <= ovf_reg ? STAT_OVERFLOW : STAT_OK;
            end
            if (cmd.move_fin) begin
                active_reg <= target_reg;
                follow_reg <= (target_reg + 1'b1 > total_reg) ? CNT_W'(1) : target_reg + 1'b1;
                green_reg  <= mask_reg;
            end
            if (cmd.out_load) begin
                out_reg.status        <= status_reg;
                out_reg.stage_count   <= total_reg;
                out_reg.current_stage <= active_reg;
                out_reg.next_stage    <= follow_reg;
                out_reg.green_phases  <= green_reg;
            end
        end
    end

    assign m_data = out_reg;

endmodule

FILE: hdl/signal_stage_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_stage_planner
// Traffic-signal stage planner: split and ring tables, plan build, stage moves.
// ----------------------------------------------------------------------------
// One command per beat, one result beat per command. A load command passes
// through the decode and done states before its result is loaded; the next
// command is taken once the block is idle again. A move walks each ring slot by
// slot, one slot a cycle, up to its terminator or the first phase that ends
// after the target stage's start. A build repeats that walk for every second of
// the cycle time, to each ring's terminator; build and move share the single
// ring walker. The result sits in an output register, so a new command is
// taken as soon as the previous one is finished, even while its result is
// still held; a second finished command waits until the held beat is taken.
module signal_stage_planner import ssp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ssp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ssp_out_t m_data
);

    ssp_cmd_t cmd;
    ssp_sts_t sts;

    // sequencer
    ssp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_data.kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // tables and walker
    ssp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

FILE: hdl/ssp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks for the stage planner.
// ----------------------------------------------------------------------------
module ssp_checker import ssp_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ssp_out_t m_data
);

    a_mhold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed");

    a_accept_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("illegal status");

    a_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stage_count != '0 |->
            m_data.next_stage != '0 && m_data.next_stage <= m_data.stage_count)
        else $error("next stage out of range");

endmodule

bind signal_stage_planner ssp_checker u_ssp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/tb_signal_stage_planner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signal_stage_planner
// Self-checking bench for the traffic-signal stage planner.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the split table, ring sequences and
// stage plan, predicts one result beat per accepted command and compares every
// result beat field by field. Stimulus is a short directed run (empty plan,
// advance, bad stage, wrap, stage overflow) followed by random ring programs:
// splits, ring slots, a build and a string of moves, mixed with raw noise.
// ----------------------------------------------------------------------------
module tb_signal_stage_planner;
    import ssp_pkg::*;

    class plan_scoreboard;
        logic [7:0]  split_tbl [PHASES];
        logic [4:0]  ring_seq [SEQ_D];
        logic [7:0]  start_tbl [MAX_STAGES];
        int          total_stages;
        int          active;
        int          follow;
        logic [15:0] green;
        ssp_out_t    due [$];
        int          errors;
        int          n_builds;
        int          n_moves;
        int          n_overflow;
        int          n_rejects;

        function new();
            foreach (split_tbl[k]) split_tbl[k] = '0;
            foreach (ring_seq[k]) ring_seq[k] = '0;
            foreach (start_tbl[k]) start_tbl[k] = '0;
            total_stages = 0;
            active = 0;
            follow = 0;
            green = '0;
            errors = 0;
            n_builds = 0;
            n_moves = 0;
            n_overflow = 0;
            n_rejects = 0;
        endfunction

        // time walk: every running total hit at time t that beats the last
        // start opens a stage
        function logic [1:0] plan_build(int cycle, int elapsed);
            int  count;
            int  last;
            int  cur;
            int  tot;
            int  id;
            bit  ovf;
            count = 1;
            last = 0;
            cur = 1;
            ovf = 0;
            foreach (start_tbl[k]) start_tbl[k] = '0;
            for (int t = 0; t < cycle; t++) begin
                for (int r = 0; r < RINGS; r++) begin
                    tot = 0;
                    for (int i = 0; i < PHASES; i++) begin
                        id = ring_seq[r * PHASES + i];
                        if (id == 0 || id > PHASES) break;
                        tot = (tot + split_tbl[id - 1]) & 255;
                        if (t == tot && tot > last) begin
                            last = tot;
                            if (count < MAX_STAGES) begin
                                count++;
                                start_tbl[count - 1] = tot[7:0];
                            end else begin
                                ovf = 1;
                            end
                        end
                    end
                end
                if (t + 1 == elapsed) cur = count;
            end
            total_stages = count;
            active = cur;
            follow = (cur + 1 > count) ? 1 : cur + 1;
            green = '0;
            return ovf ? STAT_OVERFLOW : STAT_OK;
        endfunction

        function void stage_enter(int stage);
            int start;
            int tot;
            int id;
            start = start_tbl[(stage - 1) % MAX_STAGES];
            active = stage;
            follow = (stage + 1 > total_stages) ? 1 : stage + 1;
            green = '0;
            for (int r = 0; r < RINGS; r++) begin
                tot = 0;
                for (int i = 0; i < PHASES; i++) begin
                    id = ring_seq[r * PHASES + i];
                    if (id == 0 || id > PHASES) break;
                    tot = (tot + split_tbl[id - 1]) & 255;
                    if (tot > start) begin
                        if (id <= 16) green[id - 1] = 1'b1;
                        break;
                    end
                end
            end
        endfunction

        function void note(ssp_in_t d);
            ssp_out_t res;
            int       target;
            res.status = STAT_OK;
            case (d.kind)
                KIND_SPLIT: begin
                    if (d.phase_index < PHASES) split_tbl[d.phase_index] = d.table_value;
                end
                KIND_SLOT: begin
                    if (d.ring_index < RINGS && d.slot_index < PHASES)
                        ring_seq[d.ring_index * PHASES + d.slot_index] =
                            (d.table_value <= PHASES) ? d.table_value[4:0] : 5'd0;
                end
                KIND_BUILD: begin
                    res.status = plan_build(d.cycle_time, d.elapsed_time);
                end
                default: begin
                    target = (d.stage_number == 0) ? follow : d.stage_number;
                    if (total_stages == 0 || target == 0 || target > total_stages)
                        res.status = STAT_NO_STAGE;
                    else
                        stage_enter(target);
                end
            endcase
            res.stage_count   = total_stages[4:0];
            res.current_stage = active[4:0];
            res.next_stage    = follow[4:0];
            res.green_phases  = green;
            due.push_back(res);
        endfunction

        function void check(ssp_out_t got);
            ssp_out_t want;
            if (due.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.stage_count !== want.stage_count) begin
                $error("stage_count: expected %0d, got %0d", want.stage_count, got.stage_count);
                errors++;
            end
            if (got.current_stage !== want.current_stage) begin
                $error("current_stage: expected %0d, got %0d",
                       want.current_stage, got.current_stage);
                errors++;
            end
            if (got.next_stage !== want.next_stage) begin
                $error("next_stage: expected %0d, got %0d", want.next_stage, got.next_stage);
                errors++;
            end
            if (got.green_phases !== want.green_phases) begin
                $error("green_phases: expected %h, got %h",
                       want.green_phases, got.green_phases);
                errors++;
            end
            if (want.status == STAT_OVERFLOW) n_overflow++;
            if (want.status == STAT_NO_STAGE) n_rejects++;
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ssp_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    ssp_out_t m_data;

    plan_scoreboard sb = new();

    bit calm;       // no idling on either side
    bit hold_long;  // ask the receiver for one long stall
    bit paused;     // sender pause already done
    int beats_sent;

    signal_stage_planner u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result monitor: sample at the rising edge, before the block's updates land.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
    end

    // Receiver: random stall bursts, one long counted stall on request,
    // always ready once the run goes calm.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_long = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("FAIL signal_stage_planner");
        $finish;
    end

    // Offer one command beat; valid stays up until the handshake.
    task automatic send_beat(ssp_in_t d);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note(d);
        beats_sent++;
    endtask

    // Drop valid first so the last accepted beat is not offered again.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Random filler so unused fields toggle every bit too.
    function automatic ssp_in_t noise_beat();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return ssp_in_t'(r[$bits(ssp_in_t)-1:0]);
    endfunction

    function automatic ssp_in_t cmd(logic [1:0] k);
        ssp_in_t d;
        d = noise_beat();
        d.kind = k;
        return d;
    endfunction

    task automatic put_split(int ph, int val);
        ssp_in_t d;
        d = cmd(KIND_SPLIT);
        d.phase_index = 4'(ph);
        d.table_value = 8'(val);
        send_beat(d);
    endtask

    task automatic put_slot(int rg, int sl, int val);
        ssp_in_t d;
        d = cmd(KIND_SLOT);
        d.ring_index  = 2'(rg);
        d.slot_index  = 4'(sl);
        d.table_value = 8'(val);
        send_beat(d);
    endtask

    task automatic do_build(int cyc, int el);
        ssp_in_t d;
        d = cmd(KIND_BUILD);
        d.cycle_time   = 8'(cyc);
        d.elapsed_time = 8'(el);
        sb.n_builds++;
        send_beat(d);
    endtask

    task automatic do_move(int stg);
        ssp_in_t d;
        d = cmd(KIND_MOVE);
        d.stage_number = 5'(stg);
        sb.n_moves++;
        send_beat(d);
    endtask

    // One well-formed plan: splits, ring rows, a build, then moves.
    task automatic ring_program();
        int  dense;
        int  len;
        int  val;
        dense = ($urandom_range(0, 5) == 0);
        repeat ($urandom_range(2, 6)) begin
            case ($urandom_range(0, 9))
                0:       val = 0;
                1:       val = $urandom_range(0, 255);
                default: val = dense ? $urandom_range(1, 3) : $urandom_range(1, 15);
            endcase
            put_split($urandom_range(0, PHASES - 1), val);
        end
        for (int r = 0; r < RINGS; r++) begin
            if ($urandom_range(0, 2) != 0) begin
                len = dense ? $urandom_range(4, 15) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) put_slot(r, i, $urandom_range(1, PHASES));
                // terminator, sometimes as an oversized id
                put_slot(r, len, ($urandom_range(0, 3) == 0) ? $urandom_range(17, 255) : 0);
            end
        end
        if ($urandom_range(0, 29) == 0)
            do_build($urandom_range(0, 255), $urandom_range(0, 255));
        else
            do_build($urandom_range(0, 60), $urandom_range(0, 255));
        repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: do_move(0);
                3, 4:    do_move($urandom_range(1, 16));
                default: do_move($urandom_range(17, 31));
            endcase
        end
    endtask

    initial begin
        ssp_in_t d;
        calm       = 1'b0;
        hold_long  = 1'b0;
        paused     = 1'b0;
        beats_sent = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty plan: moves are refused, advance included.
        do_move(0);
        do_move(1);
        // Zero-length cycle still yields one stage.
        do_build(0, 0);
        do_move(0);
        // Extremes of the tables: wrapping split, oversized id, last ring slot.
        put_split(PHASES - 1, 255);
        put_slot(RINGS - 1, PHASES - 1, 255);
        // One ring of sixteen 1 s splits: more starts than the stage table holds.
        put_split(0, 1);
        for (int i = 0; i < PHASES; i++) put_slot(0, i, 1);
        do_build(20, 5);
        do_move(0);
        do_move(16);
        do_move(17);
        do_build(255, 255);
        do_move(31);

        // Random part.
        while (beats_sent < 1850) begin
            if (beats_sent >= 1700) calm = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    d = noise_beat();
                    if (d.kind == KIND_BUILD && $urandom_range(0, 7) != 0)
                        d.cycle_time = d.cycle_time & 8'h1F;
                    send_beat(d);
                end
            end else begin
                ring_program();
            end
            // Long receiver stall while the sender keeps offering moves.
            if (beats_sent > 600 && beats_sent < 700 && !hold_long && !calm) begin
                hold_long = 1'b1;
                repeat (12) do_move(0);
            end
            // Sender pause until the pipe is empty.
            if (beats_sent > 1200 && !paused) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end

        $display("Sent %0d commands: %0d builds, %0d moves.",
                 beats_sent, sb.n_builds, sb.n_moves);
        $display("Saw %0d overflowed builds and %0d refused moves.",
                 sb.n_overflow, sb.n_rejects);
        if (sb.errors == 0) begin
            $display("PASS signal_stage_planner");
        end else begin
            $display("FAIL signal_stage_planner");
        end
        $finish;
    end

endmodule
